// File: rtl/tit_pkg.sv
// Shared types and constants for the tag interning table.
// Used by every module of the block but tit_ram; depends on nothing else.
`timescale 1ns / 1ps

package tit_pkg;

  localparam int NAME_W      = 32;
  localparam int MASK_W      = 32;
  localparam int ENT_IDX_W   = 10;
  localparam int CMD_W       = 3;

  localparam int DEF_TAG_SLOTS    = 32;
  localparam int DEF_ENTITY_COUNT = 1024;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Command codes as they arrive on the cmd port.
  localparam logic [CMD_W-1:0] CMD_FIND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DESCRIBE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HAS      = 3'd5;

  // Decoded operation; codes with no meaning become OP_NONE.
  typedef enum logic [2:0] {
    OP_FIND,
    OP_REGISTER,
    OP_DESCRIBE,
    OP_ADD,
    OP_REMOVE,
    OP_HAS,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [NAME_W-1:0]    name_id;
    logic [MASK_W-1:0]    select_mask;
    logic [ENT_IDX_W-1:0] entity_index;
    logic                 name_ok;
    logic                 ent_ok;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_ONE,
    ST_MOD,
    ST_LIST
  } state_t;

endpackage

// File: rtl/tit_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the entity tag mask store.
`timescale 1ns / 1ps

module tit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tit_front.sv
// Input stage: accepts command beats, decodes them and hands them to the queue.
// Depends on tit_pkg.
`timescale 1ns / 1ps

module tit_front
  import tit_pkg::*;
#(
  parameter int ENTITY_COUNT = DEF_ENTITY_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [NAME_W-1:0]    name_id,
  input  logic [MASK_W-1:0]    select_mask,
  input  logic [ENT_IDX_W-1:0] entity_index,
  input  logic                 hold,
  output logic                 push_valid,
  output item_t                push_item,
  input  logic                 push_full
);

  logic  f_valid;
  item_t f_item;
  item_t dec;
  logic  accept;

  assign in_stall   = hold || (f_valid && push_full);
  assign accept     = in_valid && !in_stall;
  assign push_valid = f_valid;
  assign push_item  = f_item;

  always_comb begin
    dec.name_id      = name_id;
    dec.select_mask  = select_mask;
    dec.entity_index = entity_index;
    dec.name_ok      = (name_id != '0);
    dec.ent_ok       = (32'(entity_index) < 32'(ENTITY_COUNT));
    case (cmd)
      CMD_FIND:     dec.op = OP_FIND;
      CMD_REGISTER: dec.op = OP_REGISTER;
      CMD_DESCRIBE: dec.op = OP_DESCRIBE;
      CMD_ADD:      dec.op = OP_ADD;
      CMD_REMOVE:   dec.op = OP_REMOVE;
      CMD_HAS:      dec.op = OP_HAS;
      default:      dec.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (f_valid && !push_full) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= dec;
    end
  end

endmodule

// File: rtl/tit_queue.sv
// Short FIFO of decoded items between the front and the back.
// Depends on tit_pkg.
`timescale 1ns / 1ps

module tit_queue
  import tit_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  localparam int PtrW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;

  assign full    = (count == CntW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign push    = push_valid && !full;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/tit_back.sv
// Execution side: name slot table with parallel match, entity mask RAM, result register.
// Depends on tit_pkg and tit_ram.
`timescale 1ns / 1ps

module tit_back
  import tit_pkg::*;
#(
  parameter int TAG_SLOTS    = DEF_TAG_SLOTS,
  parameter int ENTITY_COUNT = DEF_ENTITY_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MASK_W-1:0] tag_bit,
  output logic [NAME_W-1:0] listed_name,
  output logic              success,
  output logic              last
);

  localparam int SlotAw = TAG_SLOTS > 1 ? $clog2(TAG_SLOTS) : 1;
  localparam int CntW   = $clog2(TAG_SLOTS + 1);
  localparam int EntAw  = ENTITY_COUNT > 1 ? $clog2(ENTITY_COUNT) : 1;

  typedef logic [TAG_SLOTS-1:0] slot_vec_t;

  state_t state, state_next;

  item_t             cur;
  logic [NAME_W-1:0] slot_names [TAG_SLOTS];
  logic [CntW-1:0]   slot_count;
  slot_vec_t         filled;
  slot_vec_t         match;
  logic              hit;
  logic              table_full;
  logic              can_append;
  logic [MASK_W-1:0] new_bit;
  logic [MASK_W-1:0] look_bit;
  logic              look_ok;
  slot_vec_t         pending_init;

  logic [MASK_W-1:0] res_bit;
  logic              res_ok;
  slot_vec_t         pending;
  logic [SlotAw-1:0] idx;
  slot_vec_t         idx_bit;
  slot_vec_t         pending_left;
  logic              list_last;
  logic [EntAw-1:0]  clr_addr;
  logic              clr_done;

  logic              out_free;
  logic              emit;
  logic              slot_we;
  logic              ram_we;
  logic              ram_re;
  logic [EntAw-1:0]  ram_waddr;
  logic [MASK_W-1:0] ram_wdata;
  logic [MASK_W-1:0] ram_rdata;
  logic [EntAw-1:0]  ent_addr;
  logic [MASK_W-1:0] emit_bit;
  logic [NAME_W-1:0] emit_name;
  logic              emit_ok;
  logic              emit_last;

  assign out_free   = !out_valid || !out_stall;
  assign clearing   = (state == ST_CLEAR);
  assign clr_done   = (clr_addr == EntAw'(ENTITY_COUNT - 1));
  assign ent_addr   = EntAw'(cur.entity_index);
  assign table_full = (slot_count == CntW'(TAG_SLOTS));

  // Names in the table are unique, so at most one comparator fires.
  always_comb begin
    for (int i = 0; i < TAG_SLOTS; i++) begin
      filled[i] = (CntW'(i) < slot_count);
      match[i]  = cur.name_ok && filled[i] && (slot_names[i] == cur.name_id);
    end
  end

  assign hit          = (match != '0);
  assign can_append   = cur.name_ok && !hit && !table_full;
  assign new_bit      = 32'(slot_vec_t'(1) << slot_count);
  assign pending_init = cur.select_mask[TAG_SLOTS-1:0] & filled;

  assign idx_bit      = slot_vec_t'(1) << idx;
  assign pending_left = pending & ~idx_bit;
  assign list_last    = (pending_left == '0);

  // Result of the lookup cycle.
  always_comb begin
    look_bit = '0;
    look_ok  = 1'b0;
    case (cur.op)
      OP_FIND: begin
        look_bit = 32'(match);
        look_ok  = hit;
      end
      OP_REGISTER: begin
        look_bit = hit ? 32'(match) : (can_append ? new_bit : '0);
        look_ok  = hit || can_append;
      end
      OP_ADD: begin
        if (cur.ent_ok) begin
          look_bit = hit ? 32'(match) : (can_append ? new_bit : '0);
        end
      end
      OP_REMOVE, OP_HAS: begin
        look_bit = 32'(match);
      end
      default: begin
        look_bit = '0;
        look_ok  = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        case (cur.op)
          OP_ADD:             state_next = (look_bit != '0) ? ST_MOD : ST_ONE;
          OP_REMOVE, OP_HAS:  state_next = cur.ent_ok ? ST_MOD : ST_ONE;
          OP_DESCRIBE:        state_next = (pending_init != '0) ? ST_LIST : ST_ONE;
          default:            state_next = ST_ONE;
        endcase
      end
      ST_ONE, ST_MOD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (pending[idx] && out_free && list_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    slot_we   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ent_addr;
    ram_wdata = '0;
    emit_bit  = res_bit;
    emit_name = '0;
    emit_ok   = res_ok;
    emit_last = 1'b1;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_IDLE: begin
        q_pop = q_valid;
      end
      ST_LOOK: begin
        slot_we = can_append && (cur.op == OP_REGISTER || (cur.op == OP_ADD && cur.ent_ok));
        ram_re  = cur.ent_ok;
      end
      ST_ONE: begin
        emit = out_free;
      end
      ST_MOD: begin
        emit = out_free;
        case (cur.op)
          OP_ADD: begin
            ram_we    = out_free;
            ram_wdata = ram_rdata | res_bit;
            emit_ok   = 1'b1;
          end
          OP_REMOVE: begin
            ram_we    = out_free;
            ram_wdata = ram_rdata & ~res_bit;
            emit_ok   = 1'b1;
          end
          default: begin
            emit_ok = ((ram_rdata & res_bit) != '0);
          end
        endcase
      end
      ST_LIST: begin
        emit      = pending[idx] && out_free;
        emit_bit  = 32'(idx_bit);
        emit_name = slot_names[idx];
        emit_ok   = 1'b1;
        emit_last = list_last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      slot_count <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (slot_we) begin
        slot_count <= slot_count + 1'b1;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (slot_we) begin
      slot_names[slot_count[SlotAw-1:0]] <= cur.name_id;
    end
    if (state == ST_LOOK) begin
      res_bit <= look_bit;
      res_ok  <= look_ok;
      pending <= pending_init;
      idx     <= '0;
    end else if (state == ST_LIST) begin
      // Unselected slots are skipped one a cycle; a selected one waits for the output.
      if (!pending[idx] || out_free) begin
        pending <= pending_left;
        idx     <= idx + 1'b1;
      end
    end
    if (emit) begin
      tag_bit     <= emit_bit;
      listed_name <= emit_name;
      success     <= emit_ok;
      last        <= emit_last;
    end
  end

  tit_ram #(
    .WIDTH(MASK_W),
    .DEPTH(ENTITY_COUNT)
  ) u_masks (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ent_addr),
    .rdata(ram_rdata)
  );

endmodule

// File: rtl/tag_interning_table_unit.sv
// Top level of the tag interning table: front decode stage, item queue, execution back end.
// Depends on tit_pkg, tit_front, tit_queue and tit_back.
`timescale 1ns / 1ps

// Interns up to TAG_SLOTS nonzero name identifiers, each represented by the one-hot bit
// of its slot, and keeps a tag mask for each of ENTITY_COUNT entities. After reset the
// mask RAM is swept to zero, one entry a cycle, and the block takes no command until
// the sweep is done. Find, register, add, remove and has each give one result beat
// and pass through three back-end steps: a queue pop, a lookup in which all slots are
// compared at once and the mask RAM read is issued, and a result step that for add and
// remove also writes the updated entity mask back. Describe steps through the slots up
// to the highest selected filled slot, giving one result beat per selected filled slot
// (last marks the final one); a describe that selects no filled slot, and an unknown
// command, give one empty last beat. A stalled output holds the back end in its result
// step. The front stage and a two-entry queue keep commands flowing in while the back
// end works or waits on a stalled output.
module tag_interning_table_unit
  import tit_pkg::*;
#(
  parameter int TAG_SLOTS    = DEF_TAG_SLOTS,
  parameter int ENTITY_COUNT = DEF_ENTITY_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [NAME_W-1:0]    name_id,
  input  logic [MASK_W-1:0]    select_mask,
  input  logic [ENT_IDX_W-1:0] entity_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MASK_W-1:0]    tag_bit,
  output logic [NAME_W-1:0]    listed_name,
  output logic                 success,
  output logic                 last
);

  logic  push_valid;
  item_t push_item;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;
  logic  clearing;

  tit_front #(
    .ENTITY_COUNT(ENTITY_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .name_id     (name_id),
    .select_mask (select_mask),
    .entity_index(entity_index),
    .hold        (clearing),
    .push_valid  (push_valid),
    .push_item   (push_item),
    .push_full   (q_full)
  );

  tit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  tit_back #(
    .TAG_SLOTS   (TAG_SLOTS),
    .ENTITY_COUNT(ENTITY_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tag_bit    (tag_bit),
    .listed_name(listed_name),
    .success    (success),
    .last       (last)
  );

endmodule

// File: rtl/tit_checker.sv
// Port-level checks on the result channel of the tag interning table.
// Depends on tit_pkg; bound to tag_interning_table_unit below.
`timescale 1ns / 1ps

module tit_checker
  import tit_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MASK_W-1:0] tag_bit,
  input logic [NAME_W-1:0] listed_name,
  input logic              success,
  input logic              last
);

  // A held beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A held beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(tag_bit) && $stable(listed_name)
                               && $stable(success) && $stable(last))
    else $error("result payload changed while stalled");

  // A tag is always a single slot bit or nothing.
  a_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(tag_bit))
    else $error("tag_bit has more than one bit set");

  // A listed name always comes with its slot bit and success.
  a_listed: assert property (@(posedge clk) disable iff (rst)
    out_valid && (listed_name != '0) |-> $onehot(tag_bit) && success)
    else $error("listed name without slot bit or success");

endmodule

bind tag_interning_table_unit tit_checker u_tit_checker (.*);
